// File: sv/mmfba_pkg.sv
package mmfba_pkg;

   localparam int MAX_ENDPOINTS = 64;
   localparam int BW_BITS       = 48;
   localparam int FLD_BITS      = BW_BITS + 1;
   localparam int IDX_BITS      = 6;
   localparam int CNT_BITS      = IDX_BITS + 1;
   localparam int STEP_BITS     = $clog2(BW_BITS);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ACCUM,
      ST_CHECK,
      ST_SEL,
      ST_DSTART,
      ST_DWAIT,
      ST_XSTART,
      ST_XWAIT,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: sv/mmfba_div.sv
// Restoring divider, one quotient bit per cycle.
module mmfba_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mmfba_pkg::BW_BITS-1:0]   dividend,
   input  logic [mmfba_pkg::CNT_BITS-1:0]  divisor,
   output logic [mmfba_pkg::BW_BITS-1:0]   quotient,
   output mmfba_pkg::div_stat_type         stat
);
   import mmfba_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [BW_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_BITS:0]    trial;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[BW_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits CNT_BITS
         rem_in = ge ? CNT_BITS'(trial - {1'b0, dvs_ff}) : CNT_BITS'(trial);
         quo_in = {quo_ff[BW_BITS-2:0], ge};
         cnt_in = cnt_ff + STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(BW_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");

endmodule

// File: sv/max_min_fair_bandwidth_allocator.sv
// Loading: one endpoint per cycle while idle.
// After the last endpoint: one scan sums kept grants, then per known demand in rising
// order one selection pass and one division (start, 48 bit steps, done), stopping once
// the share fits the pick, else one more division for the leftover; then the grants go out.
// Throughput is set by the single shared serial divider and the selection scans.
// Reset clears the limit, counts and state; endpoint stores are undefined.
module max_min_fair_bandwidth_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mmfba_pkg::BW_BITS-1:0]    csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [mmfba_pkg::FLD_BITS-1:0] req_demand,
   input  logic signed [mmfba_pkg::FLD_BITS-1:0] req_previous_grant,
   input  logic                             req_last_endpoint,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mmfba_pkg::IDX_BITS-1:0]   rsp_endpoint_index,
   output logic signed [mmfba_pkg::FLD_BITS-1:0] rsp_grant,
   output logic                             rsp_last_grant
);
   import mmfba_pkg::*;

   state_type            state_ff, state_in;
   logic [BW_BITS-1:0]   total_ff;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]  n_ff, n_in;
   logic [CNT_BITS-1:0]  known_ff, known_in;
   logic [BW_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]  scan_addr_ff, scan_addr_in;
   logic                 scan_pend_ff, scan_pend_in;
   logic [IDX_BITS-1:0]  scan_pidx_ff, scan_pidx_in;
   logic                 have_prev_ff, have_prev_in;
   logic [BW_BITS-1:0]   prev_val_ff, prev_val_in;
   logic [IDX_BITS-1:0]  prev_idx_ff, prev_idx_in;
   logic                 found_ff, found_in;
   logic [BW_BITS-1:0]   best_val_ff, best_val_in;
   logic [IDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [CNT_BITS-1:0]  step_ff, step_in;
   logic [BW_BITS-1:0]   base_ff, base_in;
   logic [BW_BITS-1:0]   extra_ff, extra_in;
   logic [CNT_BITS-1:0]  emit_ff, emit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [FLD_BITS-1:0]  rsp_grant_ff, rsp_grant_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [FLD_BITS-1:0]  dem_mem [MAX_ENDPOINTS];
   logic [FLD_BITS-1:0]  gnt_mem [MAX_ENDPOINTS];
   logic [FLD_BITS-1:0]  rd_dem_ff, rd_gnt_ff;
   logic [IDX_BITS-1:0]  rd_addr;
   logic                 wr_en;

   logic                 in_acc, scan_run, scan_end;
   logic                 div_start;
   logic [BW_BITS-1:0]   div_dividend;
   logic [CNT_BITS-1:0]  div_divisor;
   logic [BW_BITS-1:0]   div_quo;
   div_stat_type         div_stat;
   logic [BW_BITS-1:0]   d_val, g_val, cap;
   logic                 cand_gt;
   logic [CNT_BITS-1:0]  cnt_inc;

   mmfba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign in_acc   = req_valid && req_ready;
   assign wr_en    = in_acc && (cnt_ff < CNT_BITS'(MAX_ENDPOINTS));
   assign scan_end = (scan_addr_ff == n_ff) && !scan_pend_ff;
   assign cnt_inc  = wr_en ? cnt_ff + CNT_BITS'(1) : cnt_ff;
   assign d_val    = rd_dem_ff[BW_BITS-1:0];
   assign g_val    = rd_gnt_ff[BW_BITS-1:0];
   assign cap      = (d_val > base_ff) ? base_ff : d_val;
   assign cand_gt  = !have_prev_ff || (d_val > prev_val_ff)
                     || ((d_val == prev_val_ff) && (scan_pidx_ff > prev_idx_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dem_mem[cnt_ff[IDX_BITS-1:0]] <= req_demand;
         gnt_mem[cnt_ff[IDX_BITS-1:0]] <= req_previous_grant;
      end
      rd_dem_ff <= dem_mem[rd_addr];
      rd_gnt_ff <= gnt_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (in_acc && req_last_endpoint) state_in = ST_ACCUM;
         ST_ACCUM:     if (scan_end) state_in = ST_CHECK;
         ST_CHECK:     state_in = (known_ff == '0) ? ST_EMIT_RD : ST_SEL;
         ST_SEL:       if (scan_end) state_in = ST_DSTART;
         ST_DSTART:    state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_stat.done) begin
               if (div_quo <= best_val_ff)                    state_in = ST_EMIT_RD;
               else if (step_ff + CNT_BITS'(1) == known_ff)   state_in = ST_XSTART;
               else                                           state_in = ST_SEL;
            end
         end
         ST_XSTART:    state_in = ST_XWAIT;
         ST_XWAIT:     if (div_stat.done) state_in = ST_EMIT_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_OUT;
         ST_EMIT_OUT:  state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (rsp_ready)
               state_in = (emit_ff + CNT_BITS'(1) == n_ff) ? ST_LOAD : ST_EMIT_RD;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready    = (state_ff == ST_LOAD);
      scan_run     = (state_ff == ST_ACCUM) || (state_ff == ST_SEL);
      rd_addr      = scan_run ? scan_addr_ff[IDX_BITS-1:0] : emit_ff[IDX_BITS-1:0];
      div_start    = (state_ff == ST_DSTART) || (state_ff == ST_XSTART);
      div_dividend = rem_ff;
      div_divisor  = (state_ff == ST_XSTART) ? known_ff : known_ff - step_ff;
   end

   // datapath next values
   always_comb begin
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      known_in     = known_ff;
      rem_in       = rem_ff;
      scan_addr_in = scan_addr_ff;
      scan_pend_in = scan_pend_ff;
      scan_pidx_in = scan_pidx_ff;
      have_prev_in = have_prev_ff;
      prev_val_in  = prev_val_ff;
      prev_idx_in  = prev_idx_ff;
      found_in     = found_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      extra_in     = extra_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_grant_in = rsp_grant_ff;
      rsp_last_in  = rsp_last_ff;

      if (scan_run) begin
         if (scan_addr_ff < n_ff) begin
            scan_addr_in = scan_addr_ff + CNT_BITS'(1);
            scan_pend_in = 1'b1;
            scan_pidx_in = scan_addr_ff[IDX_BITS-1:0];
         end else begin
            scan_pend_in = 1'b0;
         end
      end

      case (state_ff)
         ST_LOAD: begin
            if (in_acc) begin
               cnt_in = cnt_inc;
               if (req_last_endpoint) begin
                  n_in         = cnt_inc;
                  rem_in       = total_ff;
                  known_in     = '0;
                  scan_addr_in = '0;
                  scan_pend_in = 1'b0;
               end
            end
         end
         ST_ACCUM: begin
            if (scan_pend_ff) begin
               if (rd_dem_ff[BW_BITS]) begin
                  // unknown demand keeps its grant; a negative grant takes nothing
                  if (!rd_gnt_ff[BW_BITS])
                     rem_in = (g_val >= rem_ff) ? '0 : rem_ff - g_val;
               end else begin
                  known_in = known_ff + CNT_BITS'(1);
               end
            end
         end
         ST_CHECK: begin
            have_prev_in = 1'b0;
            found_in     = 1'b0;
            step_in      = '0;
            emit_in      = '0;
            scan_addr_in = '0;
            scan_pend_in = 1'b0;
         end
         ST_SEL: begin
            // next smallest (value, index) pair after the previous pick
            if (scan_pend_ff && !rd_dem_ff[BW_BITS] && cand_gt
                && (!found_ff || (d_val < best_val_ff))) begin
               best_val_in = d_val;
               best_idx_in = scan_pidx_ff;
               found_in    = 1'b1;
            end
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               base_in = div_quo;
               if (div_quo <= best_val_ff) begin
                  extra_in = '0;
               end else begin
                  rem_in       = rem_ff - best_val_ff;
                  step_in      = step_ff + CNT_BITS'(1);
                  have_prev_in = 1'b1;
                  prev_val_in  = best_val_ff;
                  prev_idx_in  = best_idx_ff;
                  found_in     = 1'b0;
                  scan_addr_in = '0;
                  scan_pend_in = 1'b0;
               end
            end
         end
         ST_XWAIT: begin
            if (div_stat.done) extra_in = div_quo;
         end
         ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = emit_ff[IDX_BITS-1:0];
            rsp_last_in  = (emit_ff + CNT_BITS'(1) == n_ff);
            if (rd_dem_ff[BW_BITS] || (known_ff == '0))
               rsp_grant_in = rd_gnt_ff;
            else
               rsp_grant_in = {1'b0, cap} + {1'b0, extra_ff};
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               emit_in      = emit_ff + CNT_BITS'(1);
               if (emit_ff + CNT_BITS'(1) == n_ff) cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         total_ff     <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         known_ff     <= '0;
         rem_ff       <= '0;
         scan_addr_ff <= '0;
         scan_pend_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) total_ff <= csr_wr_data;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         known_ff     <= known_in;
         rem_ff       <= rem_in;
         scan_addr_ff <= scan_addr_in;
         scan_pend_ff <= scan_pend_in;
         have_prev_ff <= have_prev_in;
         found_ff     <= found_in;
         step_ff      <= step_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_pidx_ff <= scan_pidx_in;
      prev_val_ff  <= prev_val_in;
      prev_idx_ff  <= prev_idx_in;
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      base_ff      <= base_in;
      extra_ff     <= extra_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_grant_ff <= rsp_grant_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_endpoint_index = rsp_idx_ff;
   assign rsp_grant          = rsp_grant_ff;
   assign rsp_last_grant     = rsp_last_ff;

   a_known_le_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD && state_ff != ST_ACCUM) |-> known_ff <= n_ff)
      else $error("known count exceeds batch size");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL) |-> step_ff < known_ff)
      else $error("water-fill step out of range");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> emit_ff < n_ff)
      else $error("grant emitted beyond batch");
   a_sel_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DSTART) |-> found_ff)
      else $error("selection pass found no demand");

endmodule

// File: tb/sv/tb_max_min_fair_bandwidth_allocator.sv
`timescale 1ns / 100ps

module tb_max_min_fair_bandwidth_allocator;

   import mmfba_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam logic [BW_BITS-1:0] LIMIT_MAX = {BW_BITS{1'b1}};
   localparam logic [FLD_BITS-1:0] UNKNOWN = {FLD_BITS{1'b1}};

   typedef struct {
      logic [FLD_BITS-1:0] demand;
      logic [FLD_BITS-1:0] prev_grant;
      logic                last;
   } endpoint_item_t;

   typedef struct {
      logic [IDX_BITS-1:0] index;
      logic [FLD_BITS-1:0] grant;
      logic                last;
   } grant_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [BW_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [FLD_BITS-1:0] req_demand = '0;
   logic signed [FLD_BITS-1:0] req_previous_grant = '0;
   logic req_last_endpoint = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [IDX_BITS-1:0] rsp_endpoint_index;
   logic signed [FLD_BITS-1:0] rsp_grant;
   logic rsp_last_grant;

   max_min_fair_bandwidth_allocator u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_demand         (req_demand),
      .req_previous_grant (req_previous_grant),
      .req_last_endpoint  (req_last_endpoint),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_endpoint_index (rsp_endpoint_index),
      .rsp_grant          (rsp_grant),
      .rsp_last_grant     (rsp_last_grant)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow state of the allocator
   logic [BW_BITS-1:0]  limit_shadow = '0;
   logic [FLD_BITS-1:0] demand_shadow [MAX_ENDPOINTS];
   logic [FLD_BITS-1:0] prev_shadow [MAX_ENDPOINTS];
   logic [63:0]         known_sorted [MAX_ENDPOINTS];
   int                  batch_fill = 0;

   endpoint_item_t pending_items [$];
   grant_beat_t    grants_due [$];

   int  mismatches = 0;
   int  grants_seen = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;
   bit  long_hold = 1'b0;
   int  gap_left = 0;
   int  stall_left = 0;

   task automatic allocate_grants(input logic [FLD_BITS-1:0] d, input logic [FLD_BITS-1:0] g,
                                  input logic last);
      logic [63:0] rem, avg, baseline, extra, v, share;
      int n, k, i, j;
      grant_beat_t beat;
      if (batch_fill < MAX_ENDPOINTS) begin
         demand_shadow[batch_fill] = d;
         prev_shadow[batch_fill] = g;
         batch_fill++;
      end
      if (!last) return;
      n = batch_fill;
      rem = {16'd0, limit_shadow};
      k = 0;
      baseline = 0;
      extra = 0;
      for (i = 0; i < n; i++) begin
         if (demand_shadow[i][BW_BITS]) begin
            if (!prev_shadow[i][BW_BITS])
               rem = (prev_shadow[i] >= rem) ? 64'd0 : rem - prev_shadow[i];
         end else begin
            known_sorted[k] = {16'd0, demand_shadow[i][BW_BITS-1:0]};
            k++;
         end
      end
      if (k > 0) begin
         for (i = 1; i < k; i++) begin
            v = known_sorted[i];
            j = i;
            while (j > 0 && known_sorted[j-1] > v) begin
               known_sorted[j] = known_sorted[j-1];
               j--;
            end
            known_sorted[j] = v;
         end
         avg = rem / k;
         for (i = 0; i < k; i++) begin
            avg = rem / (k - i);
            if (avg <= known_sorted[i]) begin
               rem = 0;
               break;
            end
            rem -= known_sorted[i];
         end
         baseline = avg;
         extra = rem / k;
      end
      for (i = 0; i < n; i++) begin
         beat.index = i[IDX_BITS-1:0];
         if (demand_shadow[i][BW_BITS] || k == 0) begin
            beat.grant = prev_shadow[i];
         end else begin
            share = (demand_shadow[i] > baseline) ? baseline : {15'd0, demand_shadow[i]};
            share = share + extra;
            beat.grant = share[FLD_BITS-1:0];
         end
         beat.last = (i == n - 1);
         grants_due.insert(grants_due.size(), beat);
      end
      batch_fill = 0;
   endtask

   // driver
   always @(posedge clock) begin
      endpoint_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready)
            allocate_grants(req_demand, req_previous_grant, req_last_endpoint);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 4) == 0) begin
               gap_left <= $urandom_range(0, 5);
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               it = pending_items.pop_front();
               req_valid <= 1'b1;
               req_demand <= it.demand;
               req_previous_grant <= it.prev_grant;
               req_last_endpoint <= it.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      grant_beat_t exp_beat;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grants_seen++;
            if (grants_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected grant beat: index %0d grant %h last %0b",
                           rsp_endpoint_index, rsp_grant, rsp_last_grant);
            end else begin
               exp_beat = grants_due.pop_front();
               if (rsp_endpoint_index !== exp_beat.index || rsp_grant !== exp_beat.grant ||
                   rsp_last_grant !== exp_beat.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("grant mismatch: exp index %0d grant %h last %0b, got %0d %h %0b",
                              exp_beat.index, exp_beat.grant, exp_beat.last,
                              rsp_endpoint_index, rsp_grant, rsp_last_grant);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !long_hold;
         end
      end
   end

   // long backpressure so the block fills and stalls its input
   // start it while grants are going out and more items wait to be sent
   initial begin
      wait (grants_seen >= 30 && rsp_valid && pending_items.size() > 0);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (600) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #12_000_000;
      $display("[max_min_fair_bandwidth_allocator] ERROR");
      $finish;
   end

   task automatic push_item(input logic [FLD_BITS-1:0] d, input logic [FLD_BITS-1:0] g,
                            input logic last);
      endpoint_item_t it;
      it.demand = d;
      it.prev_grant = g;
      it.last = last;
      pending_items.insert(pending_items.size(), it);
      items_sent++;
   endtask

   task automatic wait_idle();
      wait (pending_items.size() == 0 && !req_valid && grants_due.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(input logic [BW_BITS-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_shadow = v;
   endtask

   function automatic logic [BW_BITS-1:0] rand_bw();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[BW_BITS-1:0] >> $urandom_range(0, BW_BITS - 1);
   endfunction

   function automatic logic [FLD_BITS-1:0] rand_field();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return UNKNOWN;
         1: return {1'b1, r[BW_BITS-1:0]};
         2: return '0;
         3: return {1'b0, LIMIT_MAX};
         4, 5: return FLD_BITS'($urandom_range(0, 5000));
         6: return {1'b0, r[BW_BITS-1:0]};
         default: return {1'b0, rand_bw()};
      endcase
   endfunction

   task automatic push_batch(input int n);
      for (int i = 0; i < n; i++)
         push_item(rand_field(), rand_field(), i == n - 1);
   endtask

   initial begin
      int nbatch;
      int sz;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: mixed known, kept grant, no previous grant
      write_limit(48'd1000);
      push_item(49'd100, 49'd5, 1'b0);
      push_item(UNKNOWN, 49'd300, 1'b0);
      push_item(49'd600, UNKNOWN, 1'b0);
      push_item(49'd2000, 49'd0, 1'b1);
      // single endpoint, zero demand
      push_item(49'd0, 49'd77, 1'b1);
      // no known demand, odd negative values
      push_item(UNKNOWN, 49'd7, 1'b0);
      push_item({1'b1, 48'h8000_0000_1234}, {1'b1, 48'h0000_0000_0005}, 1'b1);
      // full-scale limit; kept grant drives remainder to zero
      write_limit(LIMIT_MAX);
      push_item({1'b0, LIMIT_MAX}, {1'b0, LIMIT_MAX}, 1'b0);
      push_item(UNKNOWN, {1'b0, LIMIT_MAX}, 1'b0);
      push_item(49'd1, 49'd1, 1'b0);
      push_item({1'b1, LIMIT_MAX}, 49'd3, 1'b1);
      push_item({1'b0, LIMIT_MAX}, 49'd0, 1'b0);
      push_item({1'b0, 48'h5555_5555_5555}, {1'b0, 48'haaaa_aaaa_aaaa}, 1'b0);
      push_item(49'd12, 49'd3, 1'b1);
      write_limit('0);
      push_item(49'd10, 49'd1, 1'b0);
      push_item(49'd20, UNKNOWN, 1'b1);
      write_limit(48'd7);
      push_item(49'd1, 49'd0, 1'b0);
      push_item(49'd5, 49'd0, 1'b0);
      push_item(49'd9, 49'd0, 1'b1);
      wait_idle();

      nbatch = 0;
      while (items_sent < 220) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: write_limit('0);
               1: write_limit(LIMIT_MAX);
               2: write_limit(BW_BITS'($urandom_range(0, 20000)));
               default: write_limit(rand_bw());
            endcase
         end
         if (nbatch == 6) sz = 70;        // overflow drops the tail
         else if (nbatch == 14) sz = 64;
         else if ($urandom_range(0, 9) == 0) sz = $urandom_range(9, 20);
         else sz = $urandom_range(1, 8);
         if (items_sent > 180) quiet = 1'b1;
         push_batch(sz);
         nbatch++;
      end
      quiet = 1'b1;
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("[max_min_fair_bandwidth_allocator] OK");
      else
         $display("[max_min_fair_bandwidth_allocator] ERROR");
      $finish;
   end

endmodule

// File: sim.f
sv/mmfba_pkg.sv
sv/mmfba_div.sv
sv/max_min_fair_bandwidth_allocator.sv
tb/sv/tb_max_min_fair_bandwidth_allocator.sv
